### rtl/sst_pkg.sv
// Shared constants, state codes and control structures of the sparse set cell tracker.
`default_nettype none
package sst_pkg;

  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;

  localparam int REQ_W       = 2;
  localparam int COORD_W     = 5;
  localparam int RND_W       = 16;
  localparam int TOTAL_W     = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int MOD_CNT_W   = $clog2(RND_W);

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PICK   = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_EXEC,
    ST_REM_FIX,
    ST_REM_CLR,
    ST_MOD,
    ST_PICK_RD,
    ST_PICK_SET,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init_wr;
    logic capture;
    logic lookup;
    logic add_commit;
    logic rem_move;
    logic rem_fix;
    logic rem_clr;
    logic mod_step;
    logic pick_rd;
    logic pick_set;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic req_add;
    logic req_remove;
    logic req_pick;
    logic in_range;
    logic set_empty;
    logic add_ok;
    logic rem_ok;
    logic mod_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/sst_mod.sv
// Bit-serial restoring remainder unit: random value modulo the member count.
`default_nettype none
module sst_mod
  import sst_pkg::*;
#(
  parameter int CW = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             step,
  input  wire logic [RND_W-1:0] dividend,
  input  wire logic [CW-1:0]    divisor,
  output logic      [CW-1:0]    rem,
  output logic                  last
);

  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RND_W-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW:0]          trial;

  // Bring down one dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial   = {rem_r, quo_r[RND_W-1]};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = MOD_CNT_W'(RND_W - 1);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (step) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = CW'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rem  = rem_r;
  assign last = (cnt_r == '0);

endmodule
`default_nettype wire

### rtl/sst_dp.sv
// Datapath: member list and cell map memories, member count, remainder unit and output register.
`default_nettype none
module sst_dp
  import sst_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [REQ_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int XW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int YW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int PAD_W = OUT_TDATA_W - (2 * COORD_W + 2 + TOTAL_W);

  logic [COORD_W-1:0] in_x, in_y;
  logic [RND_W-1:0]   in_rnd;

  logic [REQ_W-1:0]   req_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [AW-1:0]      cell_r;
  logic               range_r;

  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      init_idx_r;
  logic [XW-1:0]      ix_r;
  logic [YW-1:0]      iy_r;
  logic [AW-1:0]      slot_r;

  logic [YW+XW-1:0]   slots_mem [CELLS];
  logic [AW:0]        soc_mem   [CELLS];
  logic [YW+XW-1:0]   slots_q_r;
  logic [AW:0]        soc_q_r;

  logic               slots_we, slots_re, soc_we, soc_re;
  logic [AW-1:0]      slots_wa, slots_ra, soc_wa;
  logic [YW+XW-1:0]   slots_wd;
  logic [AW:0]        soc_wd;

  logic [AW-1:0]      slot_sel, last_cell;
  logic [CW-1:0]      rem;
  logic               mod_last;

  logic [COORD_W-1:0] px_r, py_r;
  logic               pv_r, chg_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign in_x   = in_tdata[COORD_W-1:0];
  assign in_y   = in_tdata[2*COORD_W-1:COORD_W];
  assign in_rnd = in_tdata[2*COORD_W +: RND_W];

  sst_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .step     (cmd.mod_step),
    .dividend (in_rnd),
    .divisor  (count_r),
    .rem      (rem),
    .last     (mod_last)
  );

  // Slot to refill on remove, pulled back onto the last member if the map is stale.
  always_comb begin
    if (CW'(soc_q_r[AW-1:0]) >= count_r) begin
      slot_sel = AW'(count_r - 1'b1);
    end else begin
      slot_sel = soc_q_r[AW-1:0];
    end
    last_cell = AW'(int'(slots_q_r[XW +: YW]) * GRID_COLS + int'(slots_q_r[XW-1:0]));
  end

  // Memory port steering.
  always_comb begin
    slots_we = 1'b0;
    slots_wa = '0;
    slots_wd = slots_q_r;
    soc_we   = 1'b0;
    soc_wa   = cell_r;
    soc_wd   = soc_q_r;
    if (cmd.init_wr) begin
      slots_we = 1'b1;
      slots_wa = init_idx_r[AW-1:0];
      slots_wd = {iy_r, ix_r};
      soc_we   = 1'b1;
      soc_wa   = init_idx_r[AW-1:0];
      soc_wd   = {1'b1, init_idx_r[AW-1:0]};
    end else if (cmd.add_commit) begin
      slots_we = 1'b1;
      slots_wa = count_r[AW-1:0];
      slots_wd = {YW'(y_r), XW'(x_r)};
      soc_we   = 1'b1;
      soc_wa   = cell_r;
      soc_wd   = {1'b1, count_r[AW-1:0]};
    end else if (cmd.rem_move) begin
      slots_we = 1'b1;
      slots_wa = slot_sel;
      slots_wd = slots_q_r;
    end else if (cmd.rem_fix) begin
      soc_we   = 1'b1;
      soc_wa   = last_cell;
      soc_wd   = {1'b1, slot_r};
    end else if (cmd.rem_clr) begin
      soc_we   = 1'b1;
      soc_wa   = cell_r;
      soc_wd   = {1'b0, slot_r};
    end
    slots_re = cmd.lookup | cmd.pick_rd;
    slots_ra = cmd.pick_rd ? rem[AW-1:0] : AW'(count_r - 1'b1);
    soc_re   = cmd.lookup;
  end

  always_ff @(posedge clk) begin
    if (slots_we) begin
      slots_mem[slots_wa] <= slots_wd;
    end
    if (slots_re) begin
      slots_q_r <= slots_mem[slots_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (soc_we) begin
      soc_mem[soc_wa] <= soc_wd;
    end
    if (soc_re) begin
      soc_q_r <= soc_mem[cell_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.add_commit) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem_move) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control registers: clearing-pass counters, member count, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_idx_r  <= '0;
      ix_r        <= '0;
      iy_r        <= '0;
      count_r     <= CW'(CELLS);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_idx_r <= init_idx_r + 1'b1;
        if (ix_r == XW'(GRID_COLS - 1)) begin
          ix_r <= '0;
          iy_r <= iy_r + 1'b1;
        end else begin
          ix_r <= ix_r + 1'b1;
        end
      end
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_tuser;
      x_r     <= in_x;
      y_r     <= in_y;
      cell_r  <= AW'(int'(in_y) * GRID_COLS + int'(in_x));
      range_r <= (int'(in_x) < GRID_COLS) && (int'(in_y) < GRID_ROWS);
      px_r    <= '0;
      py_r    <= '0;
      pv_r    <= 1'b0;
      chg_r   <= 1'b0;
    end
    if (cmd.add_commit || cmd.rem_move) begin
      chg_r <= 1'b1;
    end
    if (cmd.rem_move) begin
      slot_r <= slot_sel;
    end
    if (cmd.pick_set) begin
      px_r <= COORD_W'(slots_q_r[XW-1:0]);
      py_r <= COORD_W'(slots_q_r[XW +: YW]);
      pv_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, TOTAL_W'(count_r), chg_r, pv_r, py_r, px_r};
    end
  end

  always_comb begin
    status.init_last  = (init_idx_r == CW'(CELLS - 1));
    status.req_add    = (req_r == REQ_ADD);
    status.req_remove = (req_r == REQ_REMOVE);
    status.req_pick   = (req_r == REQ_PICK);
    status.in_range   = range_r;
    status.set_empty  = (count_r == '0);
    status.add_ok     = !soc_q_r[AW] && (count_r < CW'(CELLS));
    status.rem_ok     = soc_q_r[AW] && (count_r != '0);
    status.mod_last   = mod_last;
    status.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CELLS))
    else $error("member count above cell count");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_commit |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("add did not raise the member count");

  a_rem_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_move |-> status.rem_ok && !status.set_empty)
    else $error("remove committed on a non-member or an empty set");

  a_pick_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick_rd |-> rem < count_r)
    else $error("pick index outside the member list");

endmodule
`default_nettype wire

### rtl/sst_ctrl.sv
// Controller state machine sequencing clearing pass, add, remove and pick.
`default_nettype none
module sst_ctrl
  import sst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((status.req_add || status.req_remove) && status.in_range) begin
          state_nxt = ST_LOOKUP;
        end else if (status.req_pick && !status.set_empty) begin
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        if (status.req_add) begin
          cmd.add_commit = status.add_ok;
        end else if (status.rem_ok) begin
          cmd.rem_move = 1'b1;
          state_nxt    = ST_REM_FIX;
        end
      end
      ST_REM_FIX: begin
        cmd.rem_fix = 1'b1;
        state_nxt   = ST_REM_CLR;
      end
      ST_REM_CLR: begin
        cmd.rem_clr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_nxt = ST_PICK_RD;
        end
      end
      ST_PICK_RD: begin
        cmd.pick_rd = 1'b1;
        state_nxt   = ST_PICK_SET;
      end
      ST_PICK_SET: begin
        cmd.pick_set = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/sparse_set_cell_tracker.sv
// Top level of the sparse set cell tracker: controller and datapath joined by command and status.
// Sequence: add and remove of an in-range cell pass through lookup and execute, a remove also
// through map fix and clear; pick runs the one-bit-a-cycle remainder unit, then reads the list.
// Throughput: one word at a time; the next word is accepted the cycle after a result is
// loaded into the output register, even while that result still waits to be taken.
// Reset: synchronous, active low; afterwards a clearing pass over all GRID_ROWS*GRID_COLS cells
// (1024 by default) fills both memories with the full set, and no input word is taken until it ends.
`default_nettype none
module sparse_set_cell_tracker
  import sst_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // cell_x[4:0], cell_y[9:5],
                                                  // random_value[25:10], zero pad
  input  wire logic [REQ_W-1:0]       in_tuser,   // req_type[1:0]
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // pick_x[4:0], pick_y[9:5], pick_valid[10],
                                                  // changed[11], member_total[22:12], zero pad
);

  // The controller walks each request through its memory steps; the datapath holds the
  // dense member list, the cell-to-slot map with its present bit, the member count, the
  // remainder unit that reduces the random value for a pick, and the output register.
  cmd_t    cmd;
  status_t status;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // A remove copies the last member into the freed slot, then repoints that member's map
  // entry, then clears the present bit of the removed cell; when the removed cell is itself
  // the last member the final write leaves it absent, as it should be.
  sst_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

### verif/sparse_set_cell_tracker_checker.sv
// Checker for the sparse set cell tracker: mirrors the set and compares every result word.
module sparse_set_cell_tracker_checker
  import sst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [REQ_W-1:0]       in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  output int                          mismatches,
  output int                          pending
);

  localparam int CELLS  = GRID_ROWS_DEF * GRID_COLS_DEF;
  localparam int CELL_W = $clog2(CELLS);

  // Packed so that pick_x lands in the lowest bits, as on the result channel.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               changed;
    logic               found;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cell_result_t;

  logic [CELL_W-1:0]  slot_cell [0:CELLS-1];
  logic [TOTAL_W-1:0] cell_slot [0:CELLS-1];
  logic               in_set    [0:CELLS-1];
  logic [TOTAL_W-1:0] members;
  cell_result_t       expected_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic fill_set();
    for (int i = 0; i < CELLS; i++) begin
      slot_cell[i] = i[CELL_W-1:0];
      cell_slot[i] = i[TOTAL_W-1:0];
      in_set[i]    = 1'b1;
    end
    members = CELLS[TOTAL_W-1:0];
  endtask

  function automatic cell_result_t apply_request(input logic [REQ_W-1:0]   req,
                                                 input logic [COORD_W-1:0] cx,
                                                 input logic [COORD_W-1:0] cy,
                                                 input logic [RND_W-1:0]   rnd);
    cell_result_t r;
    int unsigned  xi;
    int unsigned  yi;
    int unsigned  cell_no;
    int unsigned  slot;
    int unsigned  last_cell;
    bit           on_grid;
    r       = '0;
    xi      = 32'(cx);
    yi      = 32'(cy);
    on_grid = (xi < GRID_COLS_DEF) && (yi < GRID_ROWS_DEF);
    cell_no = yi * GRID_COLS_DEF + xi;
    case (req)
      REQ_ADD: begin
        if (on_grid && !in_set[cell_no] && members < CELLS) begin
          slot_cell[members] = cell_no[CELL_W-1:0];
          cell_slot[cell_no] = members;
          in_set[cell_no]    = 1'b1;
          members            = members + 1'b1;
          r.changed          = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (on_grid && in_set[cell_no] && members != 0) begin
          slot = 32'(cell_slot[cell_no]);
          if (slot >= members) slot = 32'(members) - 1;
          last_cell            = 32'(slot_cell[members - 1'b1]);
          slot_cell[slot]      = last_cell[CELL_W-1:0];
          cell_slot[last_cell] = slot[TOTAL_W-1:0];
          members              = members - 1'b1;
          in_set[cell_no]      = 1'b0;
          r.changed            = 1'b1;
        end
      end
      REQ_PICK: begin
        if (members != 0) begin
          cell_no = 32'(slot_cell[int'(rnd) % int'(members)]);
          r.x     = COORD_W'(cell_no % GRID_COLS_DEF);
          r.y     = COORD_W'(cell_no / GRID_COLS_DEF);
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = members;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    cell_result_t want;
    cell_result_t got;
    if (!rst_n) begin
      fill_set();
      expected_q.delete();
    end else begin
      // A result is loaded only after its request has been captured and decoded, so
      // a result word taken at this edge never belongs to a request word taken at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(cell_result_t)-1:0];
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none, got %h", $time, out_tdata);
        end else begin
          want = expected_q.pop_front();
          compare_field("pick_x", 32'(want.x), 32'(got.x));
          compare_field("pick_y", 32'(want.y), 32'(got.y));
          compare_field("pick_valid", 32'(want.found), 32'(got.found));
          compare_field("changed", 32'(want.changed), 32'(got.changed));
          compare_field("member_total", 32'(want.total), 32'(got.total));
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(in_tuser, in_tdata[4:0], in_tdata[9:5], in_tdata[25:10]);
        expected_q.insert(expected_q.size(), want);
      end
    end
    pending = expected_q.size();
  end

endmodule

### verif/sparse_set_cell_tracker_tb.sv
// Top of the sparse set cell tracker testbench: clock, reset, stimulus, flow control and verdict.
module sparse_set_cell_tracker_tb
  import sst_pkg::*;
;

  // The block has no code for request type 3; it must leave the set alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int CELLS         = GRID_ROWS_DEF * GRID_COLS_DEF;
  // Longest run of cycles with no word moving on either channel. It lies well
  // above both the clearing pass after reset and the long receiver hold of
  // HOLD_CYCLES, so this leaves a wide margin over the slowest correct behaviour.
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // cell_x[4:0], cell_y[9:5], random_value[25:10]
  logic [REQ_W-1:0]       in_tuser   = REQ_ADD; // req_type[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // pick_x, pick_y, pick_valid, changed, total
  int                     mismatches;
  int                     pending;
  int                     sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sparse_set_cell_tracker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sparse_set_cell_tracker_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Idle gaps: mostly none, often short, now and then a long pause.
  function automatic int random_gap();
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 60) return 0;
    if (roll < 90) return int'($urandom_range(3, 1));
    return int'($urandom_range(40, 6));
  endfunction

  // Offers one request word and returns at the edge where it is taken. The
  // valid stays high into the next word unless a gap is chosen, so back-to-back
  // words are offered without a bubble. Every 250 words a stretch of 50 goes
  // through with no gaps at all.
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] cx,
                          input logic [COORD_W-1:0] cy, input logic [RND_W-1:0] rnd);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_TDATA_W-2*COORD_W-RND_W){1'b0}}, rnd, cy, cx};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = ((sent % 250) < 50) ? 0 : random_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A random request. With the small pool most cells come from a four by four
  // corner, so that adds and removes keep hitting both members and non-members
  // while the set stays small enough for empty picks to turn up.
  task automatic random_req(input bit small_pool);
    logic [REQ_W-1:0]   req;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [RND_W-1:0]   rnd;
    int                 roll;
    roll = int'($urandom_range(99));
    if (roll < 35)      req = REQ_ADD;
    else if (roll < 70) req = REQ_REMOVE;
    else if (roll < 95) req = REQ_PICK;
    else                req = REQ_UNUSED;
    if (small_pool && $urandom_range(99) < 85) begin
      cx = COORD_W'($urandom_range(3));
      cy = COORD_W'($urandom_range(3));
    end else begin
      cx = COORD_W'($urandom_range(31));
      cy = COORD_W'($urandom_range(31));
    end
    rnd = ($urandom_range(4) == 0) ? RND_W'($urandom_range(15)) :
                                     RND_W'($urandom_range(16'hFFFF));
    send_req(req, cx, cy, rnd);
  endtask

  initial begin : stimulus
    int order [CELLS];
    int j;
    int tmp;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The set starts full, with cell i in slot i, so the first
    // picks land on known cells and the first remove pulls the last member
    // down into the freed slot.
    send_req(REQ_PICK,   5'd0,  5'd0,  16'h0000);
    send_req(REQ_PICK,   5'd0,  5'd0,  16'hFFFF);
    send_req(REQ_ADD,    5'd5,  5'd7,  16'h1234);  // add of a member changes nothing
    send_req(REQ_ADD,    5'd31, 5'd31, 16'h0000);
    send_req(REQ_REMOVE, 5'd0,  5'd0,  16'h0000);
    send_req(REQ_PICK,   5'd31, 5'd31, 16'h0000);  // slot 0 now holds the old last member
    send_req(REQ_REMOVE, 5'd31, 5'd31, 16'hFFFF);
    send_req(REQ_REMOVE, 5'd0,  5'd0,  16'h0000);  // remove of a non-member
    send_req(REQ_PICK,   5'd0,  5'd0,  16'hFFFF);
    send_req(REQ_ADD,    5'd0,  5'd0,  16'h0000);
    send_req(REQ_ADD,    5'd31, 5'd31, 16'h0000);
    send_req(REQ_PICK,   5'd0,  5'd0,  16'd1022);
    send_req(REQ_PICK,   5'd0,  5'd0,  16'd1023);
    send_req(REQ_UNUSED, 5'd31, 5'd31, 16'hFFFF);
    send_req(REQ_UNUSED, 5'd0,  5'd0,  16'h0000);
    send_req(REQ_REMOVE, 5'd31, 5'd0,  16'h0000);
    send_req(REQ_REMOVE, 5'd0,  5'd31, 16'h0000);
    send_req(REQ_ADD,    5'd31, 5'd0,  16'h0000);
    send_req(REQ_PICK,   5'd0,  5'd0,  16'h8000);
    send_req(REQ_PICK,   5'd0,  5'd0,  16'h0001);
    // With a 32 by 32 grid every 5-bit coordinate is on the grid, so the
    // off-grid case cannot be reached through these ports.

    // Drain: remove every cell in a shuffled order, with the odd pick in
    // between, so the set shrinks through every size down to empty.
    for (int i = 0; i < CELLS; i++) order[i] = i;
    for (int i = CELLS - 1; i > 0; i--) begin
      j        = int'($urandom_range(i));
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < CELLS; i++) begin
      if ($urandom_range(47) == 0)
        send_req(REQ_PICK, COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                 RND_W'($urandom_range(16'hFFFF)));
      send_req(REQ_REMOVE, COORD_W'(order[i] % GRID_COLS_DEF),
               COORD_W'(order[i] / GRID_COLS_DEF), RND_W'($urandom_range(16'hFFFF)));
    end

    // The set is empty now: picks must come back without a member.
    send_req(REQ_PICK,   5'd0,  5'd0,  16'h0000);
    send_req(REQ_PICK,   5'd31, 5'd31, 16'hFFFF);
    send_req(REQ_REMOVE, 5'd3,  5'd3,  16'h0000);
    send_req(REQ_UNUSED, 5'd1,  5'd2,  16'h00FF);

    // Random requests around a small set.
    repeat (25) random_req(1'b1);
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("sparse_set_cell_tracker regression: pass");
    else
      $display("sparse_set_cell_tracker regression: fail");
    $finish;
  end

  // Result side. Outside a run of 60 words in every 300, each result word is followed by a random gap; twice the
  // receiver holds off for a long stretch so that the output register stays
  // full and the block has to stall the request channel.
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (taken == 150 || taken == 700) gap = HOLD_CYCLES;
      else if ((taken % 300) < 60)      gap = 0;
      else                              gap = random_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Ends the run when neither channel has moved a word for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("sparse_set_cell_tracker regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/sst_pkg.sv
rtl/sst_mod.sv
rtl/sst_dp.sv
rtl/sst_ctrl.sv
rtl/sparse_set_cell_tracker.sv
verif/sparse_set_cell_tracker_checker.sv
verif/sparse_set_cell_tracker_tb.sv
